### hw/rtl/qte_pkg.sv
package qte_pkg;

	// default sizes
	localparam int DEF_QUAT_WIDTH    = 16;
	localparam int DEF_ANGLE_WIDTH   = 16;
	localparam int DEF_CORDIC_STAGES = 16;

	// configuration registers
	localparam int FOLD_W     = 15;
	localparam int COS_W      = 11;
	localparam int CFG_DATA_W = 15;
	localparam logic [FOLD_W-1:0] FOLD_THR_RST = 15'd12867;
	localparam logic [COS_W-1:0]  COS_THR_RST  = 11'd1;

	typedef enum logic [0:0] {
		REG_FOLD_THR = 1'b0,
		REG_COS_THR  = 1'b1
	} cfg_reg_t;

	// internal Q.28 terms and angle constants in Q.24 radians
	localparam int  TW          = 36;
	localparam int  Q14_W       = 16;
	localparam int  PROD_W      = 32;
	localparam longint PI24        = 52707179;
	localparam longint HALF_PI24   = 26353589;
	localparam longint TENTH_DEG24 = 29282;

	// integer square root: radicand up to 2^56, root up to 2^28
	localparam int SQ_N   = 29;
	localparam int RAD_W  = 57;
	localparam int ROOT_W = 29;
	localparam int SPA_W  = 28;

	// CORDIC datapath
	localparam int CX_W = 38;
	localparam int CZ_W = 29;

	typedef struct packed {
		logic signed [TW-1:0] sr;
		logic signed [TW-1:0] cr;
		logic signed [TW-1:0] sy;
		logic signed [TW-1:0] cy;
		logic signed [TW-1:0] sp;
		logic                 sat;
		logic                 yz;
	} side_t;

	typedef struct packed {
		logic sat;
		logic sat_neg;
		logic yz;
	} flags_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic signed [CX_W-1:0] x;
		logic signed [CX_W-1:0] y;
		logic signed [CZ_W-1:0] z;
		logic                   zero;
	} cvec_t;

	// atan(2^-i) in Q.24
	function automatic int atan_tab(input int i);
		int r;
		unique case (i)
			0:  r = 13176795;
			1:  r = 7778716;
			2:  r = 4110060;
			3:  r = 2086331;
			4:  r = 1047214;
			5:  r = 524117;
			6:  r = 262123;
			7:  r = 131069;
			8:  r = 65536;
			9:  r = 32768;
			10: r = 16384;
			11: r = 8192;
			12: r = 4096;
			13: r = 2048;
			14: r = 1024;
			15: r = 512;
			16: r = 256;
			17: r = 128;
			18: r = 64;
			19: r = 32;
			20: r = 16;
			21: r = 8;
			22: r = 4;
			23: r = 2;
			24: r = 1;
			default: r = 0;
		endcase
		return r;
	endfunction

	// fold left half plane onto right half plane, flag the zero vector
	function automatic cvec_t cordic_pre(input logic signed [CX_W-1:0] y,
		input logic signed [CX_W-1:0] x);
		cvec_t r;
		r.zero = (x == '0) && (y == '0);
		if (x < 0) begin
			r.x = -x;
			r.y = -y;
			r.z = (y >= 0) ? CZ_W'(PI24) : -CZ_W'(PI24);
		end else begin
			r.x = x;
			r.y = y;
			r.z = '0;
		end
		return r;
	endfunction

endpackage

### hw/rtl/quaternion_to_euler_angles.sv
// Channel   Direction  Handshake              Payload
// command   in         start / busy           quat_x, quat_y, quat_z, quat_w
// result    out        done (one-cycle pulse) roll_angle, pitch_angle, yaw_angle,
//                                             pitch_quadrant, pitch_saturated
// config    in         cfg_wr_en              cfg_index, cfg_wdata
//
// One transfer per clock: busy is always low, so a quaternion can be taken on
// every cycle. Each result passes through the 29-cell square root chain and
// the CORDIC cell chain that follows it.
// Reset clears the valid line and loads the register defaults; no items in
// flight survive it. The receiver cannot stall: done is a single-cycle strobe.
module quaternion_to_euler_angles #(
	parameter int QUAT_WIDTH    = qte_pkg::DEF_QUAT_WIDTH,
	parameter int ANGLE_WIDTH   = qte_pkg::DEF_ANGLE_WIDTH,
	parameter int CORDIC_STAGES = qte_pkg::DEF_CORDIC_STAGES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [QUAT_WIDTH-1:0]        quat_x,
	input  logic signed [QUAT_WIDTH-1:0]        quat_y,
	input  logic signed [QUAT_WIDTH-1:0]        quat_z,
	input  logic signed [QUAT_WIDTH-1:0]        quat_w,
	input  logic                                cfg_wr_en,
	input  qte_pkg::cfg_reg_t                   cfg_index,
	input  logic [qte_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output logic                                done,
	output logic signed [ANGLE_WIDTH-1:0]       roll_angle,
	output logic signed [ANGLE_WIDTH-1:0]       pitch_angle,
	output logic signed [ANGLE_WIDTH-1:0]       yaw_angle,
	output logic [1:0]                          pitch_quadrant,
	output logic                                pitch_saturated
);
	import qte_pkg::*;

	// total register stages: in, products, sums, radicand, sqrt, pre, cordic,
	// fold, out
	localparam int LAT = 4 + SQ_N + 1 + CORDIC_STAGES + 2;

	// Q.24 -> Q3.(ANGLE_WIDTH-3): round half up when narrowing, exact when widening
	localparam int RS  = 27 - ANGLE_WIDTH;
	localparam int RSP = (RS > 0) ? RS : 0;
	localparam int RSN = (RS < 0) ? -RS : 0;
	localparam longint RND = (longint'(1) << RSP) >> 1;
	localparam int AIW = ANGLE_WIDTH + 4;
	localparam int EW  = CZ_W + 7;

	localparam longint PA_L   = ((PI24 + RND) >>> RSP) <<< RSN;
	localparam longint HP_L   = ((HALF_PI24 + RND) >>> RSP) <<< RSN;
	localparam longint HN_L   = ((-HALF_PI24 + RND) >>> RSP) <<< RSN;
	localparam longint BIAS_L = ((TENTH_DEG24 + RND) >>> RSP) <<< RSN;

	localparam logic signed [AIW-1:0] PA_A   = AIW'(PA_L);
	localparam logic signed [AIW-1:0] PA2_A  = AIW'(2 * PA_L);
	localparam logic signed [AIW-1:0] HP_A   = AIW'(HP_L);
	localparam logic signed [AIW-1:0] HN_A   = AIW'(HN_L);
	localparam logic signed [AIW-1:0] BIAS_A = AIW'(BIAS_L);
	localparam logic signed [AIW-1:0] Q1_A   = AIW'(HP_L);
	localparam logic signed [AIW-1:0] Q2_A   = AIW'(2 * HP_L);
	localparam logic signed [AIW-1:0] Q3_A   = AIW'(3 * HP_L);
	localparam logic signed [AIW-1:0] Q4_A   = AIW'(4 * HP_L);

	// input scaling to Q2.14
	localparam int QSR = (QUAT_WIDTH > Q14_W) ? QUAT_WIDTH - Q14_W : 0;
	localparam int QSL = (QUAT_WIDTH < Q14_W) ? Q14_W - QUAT_WIDTH : 0;
	localparam int QEW = QUAT_WIDTH + Q14_W;

	function automatic logic signed [Q14_W-1:0] to_q14(
		input logic signed [QUAT_WIDTH-1:0] v);
		logic signed [QEW-1:0] e;
		e = QEW'(v);
		e = (e >>> QSR) <<< QSL;
		return e[Q14_W-1:0];
	endfunction

	function automatic logic signed [AIW-1:0] to_ang(
		input logic signed [CZ_W-1:0] z, input logic zero);
		logic signed [EW-1:0] e;
		e = zero ? '0 : EW'(z);
		e = EW'((e + EW'(RND)) >>> RSP) <<< RSN;
		return AIW'(e);
	endfunction

	// ---------------- configuration ----------------
	logic [FOLD_W-1:0] fold_thr_q;
	logic [COS_W-1:0]  cos_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_thr_q <= FOLD_THR_RST;
			cos_thr_q  <= COS_THR_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FOLD_THR: fold_thr_q <= cfg_wdata[FOLD_W-1:0];
				REG_COS_THR:  cos_thr_q  <= cfg_wdata[COS_W-1:0];
			endcase
		end
	end

	// ---------------- valid line ----------------
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	assign busy = 1'b0;
	assign done = vld_q[LAT-1];

	// ---------------- stage 1: capture, scale ----------------
	logic signed [Q14_W-1:0] qx_s1, qy_s1, qz_s1, qw_s1;

	always_ff @(posedge clk) begin
		qx_s1 <= to_q14(quat_x);
		qy_s1 <= to_q14(quat_y);
		qz_s1 <= to_q14(quat_z);
		qw_s1 <= to_q14(quat_w);
	end

	// ---------------- stage 2: products (Q.28) ----------------
	logic signed [PROD_W-1:0] wx_s2, yz_s2, xx_s2, yy_s2, zz_s2;
	logic signed [PROD_W-1:0] wy_s2, zx_s2, wz_s2, xy_s2;

	always_ff @(posedge clk) begin
		wx_s2 <= qw_s1 * qx_s1;
		yz_s2 <= qy_s1 * qz_s1;
		xx_s2 <= qx_s1 * qx_s1;
		yy_s2 <= qy_s1 * qy_s1;
		zz_s2 <= qz_s1 * qz_s1;
		wy_s2 <= qw_s1 * qy_s1;
		zx_s2 <= qz_s1 * qx_s1;
		wz_s2 <= qw_s1 * qz_s1;
		xy_s2 <= qx_s1 * qy_s1;
	end

	// ---------------- stage 3: terms, flags ----------------
	localparam logic signed [TW-1:0] ONE28 = TW'(1) <<< 28;

	logic signed [TW-1:0] sr_c, cr_c, sp_c, cy_c, sy_c, sp_abs, cy_abs;
	logic                 sat_c, yz_c;

	always_comb begin
		sr_c   = (TW'(wx_s2) + TW'(yz_s2)) <<< 1;
		cr_c   = ONE28 - ((TW'(xx_s2) + TW'(yy_s2)) <<< 1);
		sp_c   = (TW'(wy_s2) - TW'(zx_s2)) <<< 1;
		cy_c   = ONE28 - ((TW'(yy_s2) + TW'(zz_s2)) <<< 1);
		sy_c   = (TW'(wz_s2) + TW'(xy_s2)) <<< 1;
		sat_c  = (sp_c >= ONE28) || (sp_c <= -ONE28);
		sp_abs = (sp_c < 0) ? -sp_c : sp_c;
		cy_abs = (cy_c < 0) ? -cy_c : cy_c;
		yz_c   = cy_abs < $signed({1'b0, TW'(cos_thr_q) << 14});
	end

	side_t            sd_s3;
	logic [SPA_W-1:0] spa_s3;

	always_ff @(posedge clk) begin
		sd_s3.sr  <= sr_c;
		sd_s3.cr  <= cr_c;
		sd_s3.sp  <= sp_c;
		sd_s3.cy  <= cy_c;
		sd_s3.sy  <= sy_c;
		sd_s3.sat <= sat_c;
		sd_s3.yz  <= yz_c;
		// clamped pitch ignores the root
		spa_s3    <= sat_c ? '0 : sp_abs[SPA_W-1:0];
	end

	// ---------------- stage 4: radicand 1 - sinp^2 ----------------
	logic [RAD_W-1:0]   rad_s4;
	logic [2*SPA_W-1:0] spsq_c;
	side_t              sd_s4;

	// full-width square of the 28-bit magnitude
	assign spsq_c = spa_s3 * spa_s3;

	always_ff @(posedge clk) begin
		rad_s4 <= (RAD_W'(1) << 56) - RAD_W'(spsq_c);
		sd_s4  <= sd_s3;
	end

	// ---------------- square root chain ----------------
	sq_t   sq_v [SQ_N+1];
	side_t sd_q [SQ_N];

	assign sq_v[0].rem  = rad_s4;
	assign sq_v[0].root = '0;

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		qte_sqrt_cell #(.BIT(SQ_N - 1 - k)) u_cell (
			.clk (clk),
			.s_i (sq_v[k]),
			.s_o (sq_v[k+1])
		);
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				sd_q[k] <= sd_s4;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				sd_q[k] <= sd_q[k-1];
			end
		end
	end

	// ---------------- CORDIC pre-rotation ----------------
	side_t  sd_end;
	cvec_t  roll_v [CORDIC_STAGES+1];
	cvec_t  pitch_v[CORDIC_STAGES+1];
	cvec_t  yaw_v  [CORDIC_STAGES+1];
	flags_t fl_pre_q;
	flags_t fl_q   [CORDIC_STAGES];

	assign sd_end = sd_q[SQ_N-1];

	always_ff @(posedge clk) begin
		roll_v[0]  <= cordic_pre(CX_W'(sd_end.sr), CX_W'(sd_end.cr));
		pitch_v[0] <= cordic_pre(CX_W'(sd_end.sp),
			$signed({{(CX_W - ROOT_W){1'b0}}, sq_v[SQ_N].root}));
		yaw_v[0]   <= cordic_pre(CX_W'(sd_end.sy), CX_W'(sd_end.cy));
		fl_pre_q.sat     <= sd_end.sat;
		fl_pre_q.sat_neg <= sd_end.sp[TW-1];
		fl_pre_q.yz      <= sd_end.yz;
	end

	// ---------------- CORDIC cell chains ----------------
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		qte_cordic_cell #(.SH(i)) u_roll (
			.clk (clk), .v_i (roll_v[i]), .v_o (roll_v[i+1])
		);
		qte_cordic_cell #(.SH(i)) u_pitch (
			.clk (clk), .v_i (pitch_v[i]), .v_o (pitch_v[i+1])
		);
		qte_cordic_cell #(.SH(i)) u_yaw (
			.clk (clk), .v_i (yaw_v[i]), .v_o (yaw_v[i+1])
		);
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				fl_q[i] <= fl_pre_q;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				fl_q[i] <= fl_q[i-1];
			end
		end
	end

	// ---------------- quadrant fold ----------------
	flags_t fl_end;
	logic signed [AIW-1:0] roll_c, pitch_c, yaw_c, thr_c;
	logic signed [AIW-1:0] roll_f_c, pitch_f_c, yaw_f_c;

	assign fl_end = fl_q[CORDIC_STAGES-1];

	always_comb begin
		thr_c   = AIW'(fold_thr_q);
		roll_c  = to_ang(roll_v[CORDIC_STAGES].z, roll_v[CORDIC_STAGES].zero);
		yaw_c   = fl_end.yz ? '0
			: to_ang(yaw_v[CORDIC_STAGES].z, yaw_v[CORDIC_STAGES].zero);
		if (fl_end.sat) begin
			pitch_c = fl_end.sat_neg ? HN_A : HP_A;
		end else begin
			pitch_c = to_ang(pitch_v[CORDIC_STAGES].z, pitch_v[CORDIC_STAGES].zero);
		end
		roll_f_c  = roll_c;
		pitch_f_c = pitch_c;
		yaw_f_c   = yaw_c;
		// first matching (roll, yaw) sign pair wins
		priority if (roll_c >= thr_c && yaw_c >= thr_c) begin
			roll_f_c  = roll_c - PA_A;
			pitch_f_c = PA_A - pitch_c;
			yaw_f_c   = yaw_c - PA_A;
		end else if (roll_c <= -thr_c && yaw_c <= -thr_c) begin
			roll_f_c  = roll_c + PA_A;
			pitch_f_c = PA_A - pitch_c;
			yaw_f_c   = yaw_c + PA_A;
		end else if (roll_c <= -thr_c && yaw_c >= thr_c) begin
			roll_f_c  = roll_c + PA_A;
			pitch_f_c = PA_A - pitch_c;
			yaw_f_c   = yaw_c - PA_A;
		end else if (roll_c >= thr_c && yaw_c <= -thr_c) begin
			roll_f_c  = roll_c - PA_A;
			pitch_f_c = -pitch_c - PA_A;
			yaw_f_c   = yaw_c + PA_A;
		end else begin
			roll_f_c  = roll_c;
		end
	end

	logic signed [AIW-1:0] roll_fs, pitch_fs, yaw_fs;
	logic                  sat_fs;

	always_ff @(posedge clk) begin
		roll_fs  <= roll_f_c;
		pitch_fs <= pitch_f_c;
		yaw_fs   <= yaw_f_c;
		sat_fs   <= fl_end.sat;
	end

	// ---------------- pitch wrap, quadrant, output ----------------
	logic signed [AIW-1:0] pw_c, pp_c, pb_c;
	logic [2:0]            qcnt_c;

	always_comb begin
		priority if (pitch_fs < -PA_A) begin
			pw_c = pitch_fs + PA2_A;
		end else if (pitch_fs > PA_A) begin
			pw_c = pitch_fs - PA2_A;
		end else begin
			pw_c = pitch_fs;
		end
		pp_c   = (pw_c < 0) ? pw_c + PA2_A : pw_c;
		pb_c   = pp_c + BIAS_A;
		qcnt_c = 3'(pb_c >= Q1_A) + 3'(pb_c >= Q2_A) + 3'(pb_c >= Q3_A)
			+ 3'(pb_c >= Q4_A);
	end

	always_ff @(posedge clk) begin
		roll_angle      <= roll_fs[ANGLE_WIDTH-1:0];
		pitch_angle     <= pw_c[ANGLE_WIDTH-1:0];
		yaw_angle       <= yaw_fs[ANGLE_WIDTH-1:0];
		pitch_quadrant  <= qcnt_c[1:0];
		pitch_saturated <= sat_fs;
	end

	// ---------------- checks ----------------
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("accepted item produced no result");

	a_lat_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without accepted item");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAT-2] |-> (pw_c >= -PA_A && pw_c <= PA_A))
		else $error("pitch wrap out of range");

endmodule

### hw/rtl/qte_sqrt_cell.sv
module qte_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic         clk,
	input  qte_pkg::sq_t s_i,
	output qte_pkg::sq_t s_o
);
	import qte_pkg::*;

	localparam int EW = RAD_W + 2;

	logic [EW-1:0] trial;
	logic [EW-1:0] rem_e;

	// trial = (root + 2^BIT)^2 - root^2
	assign trial = (EW'(s_i.root) << (BIT + 1)) + (EW'(1) << (2 * BIT));
	assign rem_e = EW'(s_i.rem);

	always_ff @(posedge clk) begin
		if (rem_e >= trial) begin
			s_o.rem  <= RAD_W'(rem_e - trial);
			s_o.root <= s_i.root | (ROOT_W'(1) << BIT);
		end else begin
			s_o <= s_i;
		end
	end

endmodule

### hw/rtl/qte_cordic_cell.sv
module qte_cordic_cell #(
	parameter int SH = 0
) (
	input  logic           clk,
	input  qte_pkg::cvec_t v_i,
	output qte_pkg::cvec_t v_o
);
	import qte_pkg::*;

	localparam logic signed [CZ_W-1:0] ANG = CZ_W'(atan_tab(SH));

	logic signed [CX_W-1:0] xs;
	logic signed [CX_W-1:0] ys;

	assign xs = v_i.x >>> SH;
	assign ys = v_i.y >>> SH;

	// rotate toward the x axis; direction from the sign of y
	always_ff @(posedge clk) begin
		v_o.zero <= v_i.zero;
		if (v_i.y > 0) begin
			v_o.x <= v_i.x + ys;
			v_o.y <= v_i.y - xs;
			v_o.z <= v_i.z + ANG;
		end else begin
			v_o.x <= v_i.x - ys;
			v_o.y <= v_i.y + xs;
			v_o.z <= v_i.z - ANG;
		end
	end

endmodule
